// ===== hw/rtl/ssp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssp_pkg
// Shared types and constants of the seven-segment PWM dimming driver.
// ----------------------------------------------------------------------------
package ssp_pkg;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_DIGIT = 2'd1,
    OP_BOARD = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    POS_L_TENS   = 3'd0,
    POS_L_UNITS  = 3'd1,
    POS_R_TENS   = 3'd2,
    POS_R_UNITS  = 3'd3,
    POS_AUX_L    = 3'd4,
    POS_AUX_R    = 3'd5,
    POS_DOT_PAIR = 3'd6
  } pos_t;

  // Per-group bits; D, F and G carry only the bits the groups own
  // (D bits 7..6, F bits 6..0, G bits 3..0).
  typedef struct packed {
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] c;
    logic [1:0] d;
    logic [7:0] e;
    logic [6:0] f;
    logic [3:0] g;
  } grp_t;

  localparam grp_t DRIVE_RESET = '{a: 8'hFF, b: 8'hFF, c: 8'hFF, d: 2'b11,
                                   e: 8'hFF, f: 7'h7F, g: 4'hF};

  localparam logic [7:0] PWM_PERIOD = 8'd200;
  localparam logic [7:0] THR_DOT    = 8'd3;
  localparam logic [7:0] THR_B4     = 8'd10;
  localparam logic [7:0] THR_B3     = 8'd40;
  localparam logic [7:0] THR_B1     = 8'd50;
  localparam logic [7:0] THR_B2G    = 8'd52;

  localparam logic [7:0] C_MASK_B1  = 8'hC9;
  localparam logic [7:0] C_MASK_B4  = 8'hF6;
  localparam logic [7:0] C_MASK_B2G = 8'hBF;

endpackage : ssp_pkg
`default_nettype wire

// ===== hw/rtl/seven_segment_pwm_driver.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// seven_segment_pwm_driver
// Six-digit seven-segment board driver with dots and PWM segment dimming.
// ----------------------------------------------------------------------------
//  channel | handshake    | payload
//  --------+--------------+-------------------------------------------------------------
//  in_     | valid, stall | op position digit score_left small_left small_right score_right
//  out_    | valid, stall | drive_a drive_b drive_c drive_d_top drive_e drive_f_low drive_g_low
//
//  One request per clock sustained while the output is not stalled. A request
//  is captured in the input register, then commits to the counter/pattern/drive
//  state, whose registered drives form the result.
//  Reset (rst_n low, synchronous) clears counter and patterns, sets all owned
//  drive bits, and empties both register stages.
//  A stalled output holds; the input register then fills and in_stall rises.
// ----------------------------------------------------------------------------
module seven_segment_pwm_driver import ssp_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] in_op,
  input  wire logic [2:0] in_position,
  input  wire logic [3:0] in_digit,
  input  wire logic [6:0] in_score_left,
  input  wire logic [3:0] in_small_left,
  input  wire logic [3:0] in_small_right,
  input  wire logic [6:0] in_score_right,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_drive_a,
  output logic [7:0]      out_drive_b,
  output logic [7:0]      out_drive_c,
  output logic [1:0]      out_drive_d_top,
  output logic [7:0]      out_drive_e,
  output logic [6:0]      out_drive_f_low,
  output logic [3:0]      out_drive_g_low
);

  // input register
  logic       req_valid_r;
  logic [1:0] op_r;
  logic [2:0] position_r;
  logic [3:0] digit_r;
  logic [6:0] score_left_r;
  logic [3:0] small_left_r;
  logic [3:0] small_right_r;
  logic [6:0] score_right_r;

  // block state; drive_r is also the result register
  logic [7:0] count_r;
  grp_t       pat_r;
  grp_t       drive_r;
  logic       out_valid_r;

  logic       out_free;
  logic       commit;
  logic       tick_commit;
  logic       set_commit;
  logic       in_take;
  logic [7:0] count_nxt;
  grp_t       drive_nxt;
  grp_t       pat_nxt;

  assign out_free    = !out_valid_r || !out_stall;
  assign commit      = req_valid_r && out_free;
  assign tick_commit = commit && (op_r == OP_TICK);
  assign set_commit  = commit && ((op_r == OP_DIGIT) || (op_r == OP_BOARD));
  assign in_stall    = req_valid_r && !out_free;
  assign in_take     = in_valid && !in_stall;

  ssp_pattern_upd u_pat (
    .op          (op_r),
    .position    (position_r),
    .digit       (digit_r),
    .score_left  (score_left_r),
    .small_left  (small_left_r),
    .small_right (small_right_r),
    .score_right (score_right_r),
    .pat         (pat_r),
    .pat_nxt     (pat_nxt)
  );

  ssp_dimmer u_dim (
    .count     (count_r),
    .drive     (drive_r),
    .pat       (pat_r),
    .count_nxt (count_nxt),
    .drive_nxt (drive_nxt)
  );

  // request payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_take) begin
      op_r          <= in_op;
      position_r    <= in_position;
      digit_r       <= in_digit;
      score_left_r  <= in_score_left;
      small_left_r  <= in_small_left;
      small_right_r <= in_small_right;
      score_right_r <= in_score_right;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      count_r     <= 8'd0;
      pat_r       <= '0;
      drive_r     <= DRIVE_RESET;
    end else begin
      if (in_take)       req_valid_r <= 1'b1;
      else if (commit)   req_valid_r <= 1'b0;
      if (commit)        out_valid_r <= 1'b1;
      else if (out_free) out_valid_r <= 1'b0;
      if (tick_commit) begin
        count_r <= count_nxt;
        drive_r <= drive_nxt;
      end
      if (set_commit) pat_r <= pat_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_drive_a     = drive_r.a;
  assign out_drive_b     = drive_r.b;
  assign out_drive_c     = drive_r.c;
  assign out_drive_d_top = drive_r.d;
  assign out_drive_e     = drive_r.e;
  assign out_drive_f_low = drive_r.f;
  assign out_drive_g_low = drive_r.g;

  // counter never reaches the period value
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r < PWM_PERIOD)
    else $error("dimming counter out of range");

  // drives move only on a committed tick
  a_drive_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$past(tick_commit)) |-> $stable(drive_r))
    else $error("drive changed without tick");

  // patterns move only on a committed set request
  a_pat_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$past(set_commit)) |-> $stable(pat_r))
    else $error("pattern changed without set request");

  // a pending result is never dropped while held off
  a_out_keep: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> out_valid_r)
    else $error("result lost under stall");

endmodule : seven_segment_pwm_driver
`default_nettype wire

// ===== hw/rtl/ssp_pattern_upd.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssp_pattern_upd
// Next segment patterns for a digit or board request.
// ----------------------------------------------------------------------------
module ssp_pattern_upd import ssp_pkg::*; (
  input  wire logic [1:0] op,
  input  wire logic [2:0] position,
  input  wire logic [3:0] digit,
  input  wire logic [6:0] score_left,
  input  wire logic [3:0] small_left,
  input  wire logic [3:0] small_right,
  input  wire logic [6:0] score_right,
  input  wire grp_t       pat,
  output grp_t            pat_nxt
);

  function automatic logic [6:0] seg7(input logic [3:0] d);
    logic [6:0] s;
    case (d)
      4'd0:    s = 7'h3F;
      4'd1:    s = 7'h06;
      4'd2:    s = 7'h5B;
      4'd3:    s = 7'h4F;
      4'd4:    s = 7'h66;
      4'd5:    s = 7'h6D;
      4'd6:    s = 7'h7D;
      4'd7:    s = 7'h07;
      4'd8:    s = 7'h7F;
      4'd9:    s = 7'h6F;
      default: s = 7'h00;
    endcase
    return s;
  endfunction

  // big1: {A7, C7, D[7:6], G[2:0]}
  function automatic logic [6:0] big1(input logic [3:0] d);
    logic [6:0] s;
    case (d)
      4'd0:    s = {1'b0, 1'b1, 2'd3, 3'd7};
      4'd1:    s = {1'b0, 1'b0, 2'd2, 3'd1};
      4'd2:    s = {1'b1, 1'b1, 2'd3, 3'd2};
      4'd3:    s = {1'b1, 1'b0, 2'd3, 3'd3};
      4'd4:    s = {1'b1, 1'b0, 2'd2, 3'd5};
      4'd5:    s = {1'b1, 1'b0, 2'd1, 3'd7};
      4'd6:    s = {1'b1, 1'b1, 2'd1, 3'd7};
      4'd7:    s = {1'b0, 1'b0, 2'd3, 3'd1};
      4'd8:    s = {1'b1, 1'b1, 2'd3, 3'd7};
      4'd9:    s = {1'b1, 1'b0, 2'd3, 3'd7};
      default: s = 7'h00;
    endcase
    return s;
  endfunction

  // big4: {B[7:2], G3}
  function automatic logic [6:0] big4(input logic [3:0] d);
    logic [6:0] s;
    case (d)
      4'd0:    s = {6'h3F, 1'b0};
      4'd1:    s = {6'h06, 1'b0};
      4'd2:    s = {6'h1B, 1'b1};
      4'd3:    s = {6'h0F, 1'b1};
      4'd4:    s = {6'h26, 1'b1};
      4'd5:    s = {6'h2D, 1'b1};
      4'd6:    s = {6'h3D, 1'b1};
      4'd7:    s = {6'h07, 1'b0};
      4'd8:    s = {6'h3F, 1'b1};
      4'd9:    s = {6'h2F, 1'b1};
      default: s = 7'h00;
    endcase
    return s;
  endfunction

  // Tables return zero above nine, which blanks the position (POS_AUX_R excepted).
  function automatic grp_t put_digit(input grp_t p, input logic [3:0] d,
                                     input logic [2:0] pos);
    grp_t       q;
    logic [6:0] t1;
    logic [6:0] t4;
    q  = p;
    t1 = big1(d);
    t4 = big4(d);
    case (pos)
      POS_L_TENS: begin
        q.a[7]   = t1[6];
        q.c[7]   = t1[5];
        q.d      = t1[4:3];
        q.g[2:0] = t1[2:0];
      end
      POS_L_UNITS: q.c[6:0] = seg7(d);
      POS_R_TENS:  q.e[6:0] = seg7(d);
      POS_R_UNITS: begin
        q.b[7:2] = t4[6:1];
        q.g[3]   = t4[0];
      end
      POS_AUX_L:   q.a[6:0] = seg7(d);
      POS_AUX_R: begin
        // above nine keeps the old pattern
        if (d <= 4'd9) q.f = seg7(d);
      end
      POS_DOT_PAIR: begin
        q.e[7] = (d <= 4'd3) && d[0];
        q.b[0] = (d <= 4'd3) && d[1];
      end
      default: ;
    endcase
    return q;
  endfunction

  // divide by ten: x*205 >> 11 is exact for x below 1029
  logic [14:0] prod_l, prod_r;
  logic [3:0]  tens_l, tens_r, units_l, units_r;
  logic [6:0]  rem_l, rem_r;
  grp_t        brd0, brd1, brd2, brd3, brd4, brd5;

  always_comb begin
    prod_l  = {8'd0, score_left} * 15'd205;
    prod_r  = {8'd0, score_right} * 15'd205;
    tens_l  = prod_l[14:11];
    tens_r  = prod_r[14:11];
    rem_l   = score_left - {tens_l, 3'b000} - {2'b00, tens_l, 1'b0};
    rem_r   = score_right - {tens_r, 3'b000} - {2'b00, tens_r, 1'b0};
    units_l = rem_l[3:0];
    units_r = rem_r[3:0];
  end

  always_comb begin
    brd0 = put_digit(pat,  tens_l,      POS_L_TENS);
    brd1 = put_digit(brd0, units_l,     POS_L_UNITS);
    brd2 = put_digit(brd1, small_left,  POS_AUX_L);
    brd3 = put_digit(brd2, small_right, POS_AUX_R);
    brd4 = put_digit(brd3, tens_r,      POS_R_TENS);
    brd5 = put_digit(brd4, units_r,     POS_R_UNITS);
    unique case (op)
      OP_DIGIT: pat_nxt = put_digit(pat, digit, position);
      OP_BOARD: pat_nxt = brd5;
      default:  pat_nxt = pat;
    endcase
  end

endmodule : ssp_pattern_upd
`default_nettype wire

// ===== hw/rtl/ssp_dimmer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssp_dimmer
// Dimming counter step: reload at period end, else threshold blanking.
// ----------------------------------------------------------------------------
module ssp_dimmer import ssp_pkg::*; (
  input  wire logic [7:0] count,
  input  wire grp_t       drive,
  input  wire grp_t       pat,
  output logic [7:0]      count_nxt,
  output grp_t            drive_nxt
);

  logic [7:0] n;

  always_comb begin
    n         = count + 8'd1;
    drive_nxt = drive;
    count_nxt = n;
    if (n >= PWM_PERIOD) begin
      count_nxt   = 8'd0;
      drive_nxt.a = pat.a;
      drive_nxt.b = pat.b;
      drive_nxt.c = pat.c;
      drive_nxt.d = drive.d | pat.d;
      drive_nxt.e = pat.e;
      drive_nxt.f = drive.f | pat.f;
      drive_nxt.g = drive.g | pat.g;
    end else begin
      if (n >= THR_B2G) drive_nxt.c = drive_nxt.c & C_MASK_B2G;
      if (n >= THR_B1) begin
        drive_nxt.a[7]   = 1'b0;
        drive_nxt.c      = drive_nxt.c & C_MASK_B1 & 8'h7F;
        drive_nxt.d      = 2'b00;
        drive_nxt.g[2:0] = 3'b000;
      end
      if (n >= THR_B3) drive_nxt.e[6:0] = 7'h00;
      if (n >= THR_B4) begin
        drive_nxt.c      = drive_nxt.c & C_MASK_B4;
        drive_nxt.b[7:2] = 6'h00;
        drive_nxt.g[3]   = 1'b0;
      end
      if (n >= THR_DOT) begin
        drive_nxt.a[6:0] = 7'h00;
        drive_nxt.f      = 7'h00;
        drive_nxt.b[0]   = 1'b0;
        drive_nxt.e[7]   = 1'b0;
      end
    end
  end

endmodule : ssp_dimmer
`default_nettype wire

// ===== sim/seven_segment_pwm_driver_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seven_segment_pwm_driver_tb
// Self-checking bench for the seven-segment PWM dimming driver. A scoreboard
// keeps its own copy of the patterns, the dimming counter and the port drives,
// predicts the drives after every accepted request and compares them field by
// field with each result, while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module seven_segment_pwm_driver_tb import ssp_pkg::*;;

  // Port group indexes into the pattern and drive arrays.
  localparam int GRP_A = 0;
  localparam int GRP_B = 1;
  localparam int GRP_C = 2;
  localparam int GRP_D = 3;
  localparam int GRP_E = 4;
  localparam int GRP_F = 5;
  localparam int GRP_G = 6;

  // Encodings the package leaves out; the block must ignore both.
  localparam logic [1:0] OP_UNUSED  = 2'd3;
  localparam logic [2:0] POS_UNUSED = 3'd7;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned LONG_HOLD   = 60;
  localparam int unsigned DRAIN_WAIT  = 10;

  // Plain seven-segment codes, used by big2, big3, small1 and small2.
  localparam logic [7:0] SEG7 [10] = '{8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66,
                                       8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F};
  // big1 is spread over A bit 7, C bit 7, D bits 7..6 and G bits 2..0.
  localparam logic [7:0] BIG1_A [10] = '{8'h00, 8'h00, 8'h80, 8'h80, 8'h80,
                                         8'h80, 8'h80, 8'h00, 8'h80, 8'h80};
  localparam logic [7:0] BIG1_C [10] = '{8'h80, 8'h00, 8'h80, 8'h00, 8'h00,
                                         8'h00, 8'h80, 8'h00, 8'h80, 8'h00};
  localparam logic [7:0] BIG1_D [10] = '{8'hC0, 8'h80, 8'hC0, 8'hC0, 8'h80,
                                         8'h40, 8'h40, 8'hC0, 8'hC0, 8'hC0};
  localparam logic [7:0] BIG1_G [10] = '{8'h07, 8'h01, 8'h02, 8'h03, 8'h05,
                                         8'h07, 8'h07, 8'h01, 8'h07, 8'h07};
  // big4 is spread over B bits 7..2 and G bit 3.
  localparam logic [7:0] BIG4_B [10] = '{8'hFC, 8'h18, 8'h6C, 8'h3C, 8'h98,
                                         8'hB4, 8'hF4, 8'h1C, 8'hFC, 8'hBC};
  localparam logic [7:0] BIG4_G [10] = '{8'h00, 8'h00, 8'h08, 8'h08, 8'h08,
                                         8'h08, 8'h08, 8'h00, 8'h08, 8'h08};

  // --------------------------------------------------------------------------
  // Scoreboard: shadow state of the driver plus the queue of expected drives.
  // --------------------------------------------------------------------------
  class drive_scoreboard;
    logic [7:0]  dim_count;
    logic [7:0]  pattern [7];
    logic [7:0]  drive [7];
    grp_t        pending_drives [$];
    int unsigned errors;

    function new();
      dim_count = '0;
      pattern = '{default: '0};
      drive[GRP_A] = DRIVE_RESET.a;
      drive[GRP_B] = DRIVE_RESET.b;
      drive[GRP_C] = DRIVE_RESET.c;
      drive[GRP_D] = {DRIVE_RESET.d, 6'b0};
      drive[GRP_E] = DRIVE_RESET.e;
      drive[GRP_F] = {1'b0, DRIVE_RESET.f};
      drive[GRP_G] = {4'b0, DRIVE_RESET.g};
      errors = 0;
    endfunction

    function int unsigned waiting();
      return pending_drives.size();
    endfunction

    // Digit update of one position; only patterns move, drives follow later.
    function void put_digit(int unsigned d, logic [2:0] p);
      bit          ok;
      int unsigned k;
      ok = (d <= 9);
      k  = ok ? d : 0;
      case (p)
        POS_L_TENS: begin
          pattern[GRP_A] &= 8'h7F;
          pattern[GRP_C] &= 8'h7F;
          pattern[GRP_D] &= 8'h3F;
          pattern[GRP_G] &= 8'hF8;
          if (ok) begin
            pattern[GRP_A] |= BIG1_A[k];
            pattern[GRP_C] |= BIG1_C[k];
            pattern[GRP_D] |= BIG1_D[k];
            pattern[GRP_G] |= BIG1_G[k];
          end
        end
        POS_L_UNITS: begin
          pattern[GRP_C] &= 8'h80;
          if (ok) pattern[GRP_C] |= SEG7[k];
        end
        POS_R_TENS: begin
          pattern[GRP_E] &= 8'h80;
          if (ok) pattern[GRP_E] |= SEG7[k];
        end
        POS_R_UNITS: begin
          pattern[GRP_B] &= 8'h03;
          pattern[GRP_G] &= 8'hF7;
          if (ok) begin
            pattern[GRP_B] |= BIG4_B[k];
            pattern[GRP_G] |= BIG4_G[k];
          end
        end
        POS_AUX_L: begin
          pattern[GRP_A] &= 8'h80;
          if (ok) pattern[GRP_A] |= SEG7[k];
        end
        POS_AUX_R: begin
          // out-of-range digit keeps the old pattern here
          if (ok) pattern[GRP_F] = SEG7[k];
        end
        POS_DOT_PAIR: begin
          pattern[GRP_B] &= 8'hFE;
          pattern[GRP_E] &= 8'h7F;
          if (d <= 3) begin
            if (d[0]) pattern[GRP_E] |= 8'h80;
            if (d[1]) pattern[GRP_B] |= 8'h01;
          end
        end
        default: ;
      endcase
    endfunction

    function void tick();
      dim_count = dim_count + 8'd1;
      if (dim_count >= PWM_PERIOD) begin
        drive[GRP_A] = pattern[GRP_A];
        drive[GRP_B] = pattern[GRP_B];
        drive[GRP_C] = pattern[GRP_C];
        drive[GRP_D] |= pattern[GRP_D] & 8'hC0;
        drive[GRP_E] = pattern[GRP_E];
        drive[GRP_F] |= pattern[GRP_F] & 8'h7F;
        drive[GRP_G] |= pattern[GRP_G] & 8'h0F;
        dim_count = '0;
        return;
      end
      if (dim_count >= THR_B2G) drive[GRP_C] &= C_MASK_B2G;
      if (dim_count >= THR_B1) begin
        drive[GRP_A] &= 8'h7F;
        drive[GRP_C] &= 8'h7F;
        drive[GRP_D] &= 8'h3F;
        drive[GRP_G] &= 8'hF8;
        drive[GRP_C] &= C_MASK_B1;
      end
      if (dim_count >= THR_B3) drive[GRP_E] &= 8'h80;
      if (dim_count >= THR_B4) begin
        drive[GRP_C] &= C_MASK_B4;
        drive[GRP_B] &= 8'h03;
        drive[GRP_G] &= 8'hF7;
      end
      if (dim_count >= THR_DOT) begin
        drive[GRP_A] &= 8'h80;
        drive[GRP_F] &= 8'h80;
        drive[GRP_B] &= 8'hFE;
        drive[GRP_E] &= 8'h7F;
      end
    endfunction

    function void note_request(logic [1:0] op, logic [2:0] p, logic [3:0] dig,
                               logic [6:0] sl, logic [3:0] s1, logic [3:0] s2,
                               logic [6:0] sr);
      grp_t r;
      case (op)
        OP_TICK:  tick();
        OP_DIGIT: put_digit(dig, p);
        OP_BOARD: begin
          put_digit(sl / 10, POS_L_TENS);
          put_digit(sl % 10, POS_L_UNITS);
          put_digit(s1, POS_AUX_L);
          put_digit(s2, POS_AUX_R);
          put_digit(sr / 10, POS_R_TENS);
          put_digit(sr % 10, POS_R_UNITS);
        end
        default: ;
      endcase
      r.a = drive[GRP_A];
      r.b = drive[GRP_B];
      r.c = drive[GRP_C];
      r.d = drive[GRP_D][7:6];
      r.e = drive[GRP_E];
      r.f = drive[GRP_F][6:0];
      r.g = drive[GRP_G][3:0];
      pending_drives.push_back(r);
    endfunction

    function void compare(string field, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s expected %h, got %h", $time, field, want, got);
      end
    endfunction

    function void check_drives(grp_t got);
      grp_t want;
      if (pending_drives.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected, got %h", $time, got);
        return;
      end
      want = pending_drives.pop_front();
      compare("drive_a", want.a, got.a);
      compare("drive_b", want.b, got.b);
      compare("drive_c", want.c, got.c);
      compare("drive_d_top", 8'(want.d), 8'(got.d));
      compare("drive_e", want.e, got.e);
      compare("drive_f_low", 8'(want.f), 8'(got.f));
      compare("drive_g_low", 8'(want.g), 8'(got.g));
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and the block under test
  // --------------------------------------------------------------------------
  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] in_op = OP_TICK;
  logic [2:0] in_position = POS_L_TENS;
  logic [3:0] in_digit = '0;
  logic [6:0] in_score_left = '0;
  logic [3:0] in_small_left = '0;
  logic [3:0] in_small_right = '0;
  logic [6:0] in_score_right = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_drive_a;
  logic [7:0] out_drive_b;
  logic [7:0] out_drive_c;
  logic [1:0] out_drive_d_top;
  logic [7:0] out_drive_e;
  logic [6:0] out_drive_f_low;
  logic [3:0] out_drive_g_low;

  // Receiver control, set by the stimulus and read at the falling edge.
  bit          hold_req = 1'b0;
  bit          hold_taken = 1'b0;
  bit          quiet_phase = 1'b0;
  int unsigned stall_left = 0;
  int unsigned free_left = 0;

  drive_scoreboard sb = new();

  always #5 clk = ~clk;

  seven_segment_pwm_driver DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_op          (in_op),
    .in_position    (in_position),
    .in_digit       (in_digit),
    .in_score_left  (in_score_left),
    .in_small_left  (in_small_left),
    .in_small_right (in_small_right),
    .in_score_right (in_score_right),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_drive_a    (out_drive_a),
    .out_drive_b    (out_drive_b),
    .out_drive_c    (out_drive_c),
    .out_drive_d_top(out_drive_d_top),
    .out_drive_e    (out_drive_e),
    .out_drive_f_low(out_drive_f_low),
    .out_drive_g_low(out_drive_g_low)
  );

  // --------------------------------------------------------------------------
  // Both handshakes are observed in one process at the rising edge, so a
  // request is always noted before any result it could produce is checked.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall)
      sb.note_request(in_op, in_position, in_digit, in_score_left,
                      in_small_left, in_small_right, in_score_right);
    if (rst_n && out_valid && !out_stall)
      sb.check_drives(grp_t'{a: out_drive_a, b: out_drive_b, c: out_drive_c,
                             d: out_drive_d_top, e: out_drive_e,
                             f: out_drive_f_low, g: out_drive_g_low});
  end

  // --------------------------------------------------------------------------
  // Receiver: random stall bursts between random free runs.
  // A requested long hold is counted here; the quiet phase never stalls.
  // An ongoing burst always runs out before anything else is decided.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (!rst_n || quiet_phase) begin
      out_stall <= 1'b0;
    end else if (hold_req && !hold_taken) begin
      hold_taken = 1'b1;
      stall_left = LONG_HOLD - 1;
      out_stall <= 1'b1;
    end else if (free_left != 0) begin
      free_left--;
      out_stall <= 1'b0;
    end else if ($urandom_range(0, 2) == 0) begin
      stall_left = $urandom_range(0, 18);
      out_stall <= 1'b1;
    end else begin
      free_left = $urandom_range(0, 30);
      out_stall <= 1'b0;
    end
  end

  // Hard stop in case the handshakes hang.
  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("seven_segment_pwm_driver regression: fail");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Sender tasks. Inputs change on the falling edge only; a request is held
  // until the rising edge that takes it.
  // --------------------------------------------------------------------------
  task automatic send_request(input logic [1:0] op, input logic [2:0] p,
                              input logic [3:0] dig, input logic [6:0] sl,
                              input logic [3:0] s1, input logic [3:0] s2,
                              input logic [6:0] sr);
    @(negedge clk);
    in_valid       <= 1'b1;
    in_op          <= op;
    in_position    <= p;
    in_digit       <= dig;
    in_score_left  <= sl;
    in_small_left  <= s1;
    in_small_right <= s2;
    in_score_right <= sr;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic sender_idle(input int unsigned n);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // Random gap before a request, outside the quiet phase.
  task automatic maybe_pause();
    if (!quiet_phase && $urandom_range(0, 4) == 0)
      sender_idle($urandom_range(1, 19));
  endtask

  task automatic send_digit(input logic [2:0] p, input logic [3:0] dig);
    send_request(OP_DIGIT, p, dig, 7'($urandom), 4'($urandom), 4'($urandom),
                 7'($urandom));
  endtask

  task automatic send_board(input logic [6:0] sl, input logic [3:0] s1,
                            input logic [3:0] s2, input logic [6:0] sr);
    send_request(OP_BOARD, 3'($urandom), 4'($urandom), sl, s1, s2, sr);
  endtask

  // Mostly ticks so the counter walks through several full dimming periods;
  // digits and scores stay mostly in range, with some blanks and overflow.
  task automatic send_random();
    int unsigned sel;
    logic [1:0]  op;
    logic [2:0]  p;
    logic [3:0]  dig;
    logic [3:0]  s1;
    logic [3:0]  s2;
    logic [6:0]  sl;
    logic [6:0]  sr;
    sel = $urandom_range(0, 99);
    if (sel < 72)      op = OP_TICK;
    else if (sel < 88) op = OP_DIGIT;
    else if (sel < 98) op = OP_BOARD;
    else               op = OP_UNUSED;
    p   = ($urandom_range(0, 15) == 0) ? POS_UNUSED : 3'($urandom_range(0, 6));
    dig = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'($urandom_range(0, 9));
    s1  = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'($urandom_range(0, 9));
    s2  = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'($urandom_range(0, 9));
    sl  = ($urandom_range(0, 7) == 0) ? 7'($urandom) : 7'($urandom_range(0, 99));
    sr  = ($urandom_range(0, 7) == 0) ? 7'($urandom) : 7'($urandom_range(0, 99));
    send_request(op, p, dig, sl, s1, s2, sr);
  endtask

  task automatic wait_drained();
    while (sb.waiting() != 0) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned n;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: reset drives, every position, blanks and the odd cases.
    send_request(OP_TICK, POS_L_TENS, 4'd0, 7'd0, 4'd0, 4'd0, 7'd0);
    send_digit(POS_L_TENS, 4'd8);
    send_digit(POS_L_UNITS, 4'd0);
    send_digit(POS_R_TENS, 4'd9);
    send_digit(POS_R_UNITS, 4'd8);
    send_digit(POS_AUX_L, 4'd7);
    send_digit(POS_AUX_R, 4'd5);
    send_digit(POS_DOT_PAIR, 4'd3);
    send_digit(POS_AUX_R, 4'd15);     // small2 keeps its pattern
    send_digit(POS_R_TENS, 4'd10);    // blank
    send_digit(POS_AUX_L, 4'd15);     // blank
    send_digit(POS_DOT_PAIR, 4'd4);   // both dots off
    send_digit(POS_DOT_PAIR, 4'd2);
    send_digit(POS_DOT_PAIR, 4'd1);
    send_digit(POS_UNUSED, 4'd5);     // ignored position
    send_request(OP_UNUSED, POS_UNUSED, 4'hF, 7'h7F, 4'hF, 4'hF, 7'h7F);
    send_board(7'd127, 4'd15, 4'd9, 7'd100);  // tens above nine blank
    send_board(7'd0, 4'd0, 4'd0, 7'd99);
    send_board(7'd99, 4'd9, 4'd12, 7'd0);
    send_digit(POS_L_TENS, 4'd15);
    send_digit(POS_R_UNITS, 4'd0);

    for (n = 0; n < 300; n++) begin
      maybe_pause();
      send_random();
    end

    // Sender pause: let everything outstanding come back.
    sender_idle(1);
    wait_drained();

    // Long receiver hold while requests keep coming, filling the block.
    hold_req = 1'b1;
    for (n = 0; n < 30; n++) send_random();

    for (n = 0; n < 400; n++) begin
      maybe_pause();
      send_random();
    end

    // Final stretch at full rate on both sides.
    quiet_phase = 1'b1;
    for (n = 0; n < 120; n++) send_random();

    sender_idle(1);
    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.errors == 0)
      $display("seven_segment_pwm_driver regression: pass");
    else
      $display("seven_segment_pwm_driver regression: fail");
    $finish;
  end

endmodule
